// ----- hdl/preemptive_priority_scheduler_assert.svh -----
// Assertion macros for the scheduler checker.
// Both expect clk to be visible where they are used; PPS_ASSERT also expects rst.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH

// Checked only outside reset.
`define PPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define PPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/ppsch_pkg.sv -----
package ppsch_pkg;

  localparam int MAX_PROCS_DEF = 16;
  localparam int TIME_BITS_DEF = 16;

  localparam int PID_W   = 8;
  localparam int ARR_W   = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int OUT_W   = 16;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BURST0 = 2'd2
  } status_t;

  typedef struct packed {
    op_t                operation;
    logic [PID_W-1:0]   proc_id;
    logic [ARR_W-1:0]   arrive_at;
    logic [BURST_W-1:0] burst_len;
    logic [PRIO_W-1:0]  prio_level;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic               ran;
    logic [PID_W-1:0]   ran_pid;
    logic               finished;
    logic [OUT_W-1:0]   turnaround;
    logic [OUT_W-1:0]   waiting;
    logic               all_done;
    logic [OUT_W-1:0]   time_now;
  } result_t;

  // Best-so-far record handed from cell to cell during a scan.
  typedef struct packed {
    logic               found;
    logic [PRIO_W-1:0]  prio;
    logic [PID_W-1:0]   pid;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] left;
  } cand_t;

endpackage

// ----- hdl/ppsch_cell.sv -----
module ppsch_cell #(
  parameter int             TW     = 16,
  parameter int             IW     = 4,
  parameter logic [IW-1:0]  MY_IDX = '0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  ppsch_pkg::item_t  item,
  input  logic              step,
  input  logic [TW-1:0]     now,
  input  ppsch_pkg::cand_t  cand_in,
  input  logic [IW-1:0]     idx_in,
  output ppsch_pkg::cand_t  cand_out,
  output logic [IW-1:0]     idx_out
);
  import ppsch_pkg::*;

  logic               valid;
  logic               done;
  logic [PID_W-1:0]   pid;
  logic [ARR_W-1:0]   arrival;
  logic [BURST_W-1:0] burst;
  logic [PRIO_W-1:0]  prio;
  logic [BURST_W-1:0] left;

  logic               eligible;
  logic               take;
  logic [BURST_W-1:0] left_dec;

  assign left_dec = left - BURST_W'(left != '0);
  assign eligible = valid && !done && (TW'(arrival) <= now);
  // strict less-than keeps the lower index on a tie
  assign take     = eligible && (!cand_in.found || (prio < cand_in.prio));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      done  <= 1'b0;
    end else if (wr) begin
      valid <= 1'b1;
      done  <= 1'b0;
    end else if (step && (left_dec == '0)) begin
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      pid     <= item.proc_id;
      arrival <= item.arrive_at;
      burst   <= item.burst_len;
      prio    <= item.prio_level;
      left    <= item.burst_len;
    end else if (step) begin
      left <= left_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cand_out.found   <= 1'b1;
      cand_out.prio    <= prio;
      cand_out.pid     <= pid;
      cand_out.arrival <= arrival;
      cand_out.burst   <= burst;
      cand_out.left    <= left;
      idx_out          <= MY_IDX;
    end else begin
      cand_out <= cand_in;
      idx_out  <= idx_in;
    end
  end

endmodule

// ----- hdl/preemptive_priority_scheduler.sv -----
// Preemptive priority scheduler over a table of MAX_PROCS process entries, one entry per
// cell in a chain. A load item writes the next free entry unless the table is full or the
// burst is zero; its result is registered in pend and then moved to the output register in
// S_PUT. A tick item sends a best-so-far record down the chain, one cell per cycle, then
// passes through S_UPDATE, S_FIN and S_PUT. After S_PUT the block returns to S_IDLE and
// can take the next item; S_PUT waits while the output register holds an untaken result.
// One item is in flight at a time; a finished result sits in the output register and the
// block takes the next item while it waits. Time saturates at 2**TIME_BITS - 1.
module preemptive_priority_scheduler #(
  parameter int MAX_PROCS = ppsch_pkg::MAX_PROCS_DEF,
  parameter int TIME_BITS = ppsch_pkg::TIME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  ppsch_pkg::item_t    item,
  output logic                result_valid,
  input  logic                result_ready,
  output ppsch_pkg::result_t  result
);
  import ppsch_pkg::*;

  localparam int IW   = $clog2(MAX_PROCS);
  localparam int CNTW = $clog2(MAX_PROCS + 1);
  localparam int CW   = (TIME_BITS > OUT_W) ? TIME_BITS : OUT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_FIN,
    S_PUT
  } state_t;

  state_t               state;
  logic [IW-1:0]        scan_cnt;
  logic [CNTW-1:0]      loaded_count;
  logic [CNTW-1:0]      done_count;
  logic [TIME_BITS-1:0] clock_time;
  cand_t                win;
  result_t              pend;

  cand_t                cand_c [0:MAX_PROCS];
  logic [IW-1:0]        idx_c  [0:MAX_PROCS];
  logic [MAX_PROCS-1:0] ld_we;
  logic [MAX_PROCS-1:0] step_en;

  logic                 load_acc;
  logic                 load_full;
  logic                 load_ok;
  logic [CNTW-1:0]      loaded_after;
  logic [TIME_BITS-1:0] time_inc;
  logic [CW-1:0]        now_ext;
  logic                 win_fin;
  logic [CW-1:0]        tat_w;
  logic [CW-1:0]        wait_w;
  cand_t                tail;

  assign item_ready   = (state == S_IDLE);
  assign load_acc     = item_valid && item_ready && (item.operation == OP_LOAD);
  assign load_full    = (loaded_count == CNTW'(MAX_PROCS));
  assign load_ok      = !load_full && (item.burst_len != '0);
  assign loaded_after = loaded_count + CNTW'(load_ok);

  assign time_inc = (clock_time == '1) ? clock_time : clock_time + 1'b1;
  assign now_ext  = CW'(clock_time);
  assign tail     = cand_c[MAX_PROCS];

  // win is latched at the update edge, clock_time already advanced here
  assign win_fin = win.found && (win.left <= BURST_W'(1));
  assign tat_w   = now_ext - CW'(win.arrival);
  assign wait_w  = (tat_w >= CW'(win.burst)) ? tat_w - CW'(win.burst) : '0;

  assign cand_c[0] = '0;
  assign idx_c[0]  = '0;

  for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
    assign ld_we[g]   = load_acc && load_ok && (loaded_count == CNTW'(g));
    assign step_en[g] = (state == S_UPDATE) && tail.found && (idx_c[MAX_PROCS] == IW'(g));

    ppsch_cell #(
      .TW     (CW),
      .IW     (IW),
      .MY_IDX (IW'(g))
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr       (ld_we[g]),
      .item     (item),
      .step     (step_en[g]),
      .now      (now_ext),
      .cand_in  (cand_c[g]),
      .idx_in   (idx_c[g]),
      .cand_out (cand_c[g+1]),
      .idx_out  (idx_c[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      loaded_count <= '0;
      done_count   <= '0;
      clock_time   <= '0;
      scan_cnt     <= '0;
    end else begin
      // S_PUT drives result_valid itself
      if (result_valid && result_ready && (state != S_PUT)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            if (item.operation == OP_TICK) begin
              scan_cnt <= '0;
              state    <= S_SCAN;
            end else begin
              pend.status     <= load_full ? ST_FULL :
                                 ((item.burst_len == '0) ? ST_BURST0 : ST_OK);
              pend.ran        <= 1'b0;
              pend.ran_pid    <= '0;
              pend.finished   <= 1'b0;
              pend.turnaround <= '0;
              pend.waiting    <= '0;
              pend.all_done   <= (done_count == loaded_after);
              pend.time_now   <= now_ext[OUT_W-1:0];
              loaded_count    <= loaded_after;
              state           <= S_PUT;
            end
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == IW'(MAX_PROCS - 1)) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          win        <= tail;
          clock_time <= time_inc;
          if (tail.found && (tail.left <= BURST_W'(1))) begin
            done_count <= done_count + 1'b1;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          pend.status     <= ST_OK;
          pend.ran        <= win.found;
          pend.ran_pid    <= win.found ? win.pid : '0;
          pend.finished   <= win_fin;
          pend.turnaround <= win_fin ? tat_w[OUT_W-1:0] : '0;
          pend.waiting    <= win_fin ? wait_w[OUT_W-1:0] : '0;
          pend.all_done   <= (done_count == loaded_count);
          pend.time_now   <= now_ext[OUT_W-1:0];
          state           <= S_PUT;
        end
        S_PUT: begin
          if (!result_valid || result_ready) begin
            result       <= pend;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/ppsch_checker.sv -----
`include "preemptive_priority_scheduler_assert.svh"

module ppsch_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input logic               result_valid,
  input logic               result_ready,
  input ppsch_pkg::result_t result
);
  import ppsch_pkg::*;

  logic stalled;
  logic rejected;
  logic run_clear;

  assign stalled   = result_valid && !result_ready;
  assign rejected  = result_valid && (result.status != ST_OK);
  assign run_clear = !result.ran && !result.finished &&
                     (result.turnaround == '0) && (result.waiting == '0);

  // a stalled result holds
  `PPS_ASSERT(a_hold, stalled |=> result_valid && $stable(result), "stalled result changed")
  `PPS_ASSERT_ALWAYS(a_rst, rst |=> !result_valid, "result valid right after reset")
  // one item at a time
  `PPS_ASSERT(a_busy, item_valid && item_ready |=> !item_ready, "ready high after an item")
  `PPS_ASSERT(a_load, rejected |-> run_clear, "rejected load with run fields set")
  `PPS_ASSERT(a_fin, result_valid && result.finished |-> result.ran, "finished without a run")

endmodule

bind preemptive_priority_scheduler ppsch_checker u_ppsch_checker (.*);
